FILE: rtl/voc_dfm_pkg.sv
// Shared constants and helpers for the VOC deframer and downmix block.
// No dependencies.
`default_nettype none
package voc_dfm_pkg;
    localparam int unsigned RATE_W = 20;
    localparam logic [RATE_W-1:0] RATE_NUM = 20'd1000000;
    localparam logic [15:0] VER_OFFSET = 16'h1234;
    localparam logic [15:0] VER_MASK   = 16'hFFFF;
    localparam logic [4:0]  HDR_LAST   = 5'd25;
    localparam logic [15:0] HDR_LEN    = 16'd26;
    localparam logic [4:0]  IDENT_LEN  = 5'd19;

    localparam logic [1:0] KIND_SAMPLE = 2'd0;
    localparam logic [1:0] KIND_FORMAT = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;
    localparam logic [1:0] KIND_BAD    = 2'd3;

    localparam logic [7:0] BLK_END   = 8'd0;
    localparam logic [7:0] BLK_SND   = 8'd1;
    localparam logic [7:0] BLK_CONT  = 8'd2;
    localparam logic [7:0] BLK_SNDEX = 8'd9;

    function automatic logic [7:0] ident_char(input logic [4:0] idx);
        logic [7:0] c;
        case (idx)
            5'd0:  c = 8'h43;
            5'd1:  c = 8'h72;
            5'd2:  c = 8'h65;
            5'd3:  c = 8'h61;
            5'd4:  c = 8'h74;
            5'd5:  c = 8'h69;
            5'd6:  c = 8'h76;
            5'd7:  c = 8'h65;
            5'd8:  c = 8'h20;
            5'd9:  c = 8'h56;
            5'd10: c = 8'h6F;
            5'd11: c = 8'h69;
            5'd12: c = 8'h63;
            5'd13: c = 8'h65;
            5'd14: c = 8'h20;
            5'd15: c = 8'h46;
            5'd16: c = 8'h69;
            5'd17: c = 8'h6C;
            5'd18: c = 8'h65;
            default: c = 8'h00;
        endcase
        return c;
    endfunction
endpackage
`default_nettype wire

FILE: rtl/voc_dfm_div.sv
// Restoring divider: constant dividend over a 9-bit divisor, one quotient bit a cycle.
// Depends on voc_dfm_pkg.
`default_nettype none
module voc_dfm_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [8:0]                    divisor,
    output logic                               done,
    output logic [voc_dfm_pkg::RATE_W-1:0]     quotient
);
    import voc_dfm_pkg::*;

    logic [4:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [9:0]        rem_reg, rem_next;
    logic [8:0]        dvs_reg, dvs_next;
    logic [RATE_W-1:0] q_reg, q_next;
    logic [9:0]        trial;

    always_comb
    begin
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        q_next    = q_reg;
        trial     = {rem_reg[8:0], RATE_NUM[cnt_reg]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'(RATE_W - 1);
            rem_next  = '0;
            q_next    = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                q_next   = {q_reg[RATE_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                q_next   = {q_reg[RATE_W-2:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 5'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire

FILE: rtl/voc_block_deframer_downmix_core.sv
// VOC byte-stream deframer with 8-bit mono downmix, top level.
// Depends on voc_dfm_pkg and voc_dfm_div.
//
// Usage: file bytes enter on the s_ channel, one per transaction; s_tuser
// marks the first byte of a new file and restarts the parser. Results leave
// on the m_ channel: m_tuser holds the kind (sample, format update, end of
// stream, bad header), m_tdata the sample and the current format.
// Each byte's result, where it has one, is registered the next cycle.
// A type 1 block's second sub-header byte starts the serial divider, which
// derives the rate from the first; s_tready is low until the format result is posted.
// A pending result blocks input: s_tready is low while m_tvalid is high and
// m_tready is low, so a stalled receiver holds the whole block.
// Reset clears the parser to the main header phase, the format to 8-bit
// mono at rate 0, and check_header to 1. cfg_wen writes check_header.
`default_nettype none
module voc_block_deframer_downmix_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wen,
    input  wire logic        cfg_wdata,    // check_header
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,      // data_byte
    input  wire logic        s_tuser,      // start_of_file
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,      // sample, sample_rate, sample_bits, channel_count
    output logic [1:0]       m_tuser       // kind
);
    import voc_dfm_pkg::*;

    typedef enum logic [2:0] {
        ST_HEADER, ST_SKIP, ST_BLKHDR, ST_SUB, ST_DATA, ST_DONE, ST_DIV
    } state_t;

    state_t            st_reg, st_next;
    logic              chk_reg, chk_next;
    logic [4:0]        fbi_reg, fbi_next;
    logic [15:0]       ofs_reg, ofs_next;
    logic [15:0]       pver_reg, pver_next;
    logic [7:0]        cver_reg, cver_next;
    logic              idm_reg, idm_next;
    logic [7:0]        bk_reg, bk_next;
    logic [23:0]       bl_reg, bl_next;
    logic [RATE_W-1:0] rate_reg, rate_next;
    logic [7:0]        bits_reg, bits_next;
    logic [7:0]        ch_reg, ch_next;
    logic [7:0]        fb0_reg, fb0_next, fb1_reg, fb1_next, fb2_reg, fb2_next;
    logic [1:0]        fi_reg, fi_next;
    logic              ov_reg, ov_next;
    logic [1:0]        okind_reg, okind_next;
    logic [7:0]        osmp_reg, osmp_next;
    logic [RATE_W-1:0] orate_reg, orate_next;
    logic [7:0]        obits_reg, obits_next, och_reg, och_next;

    logic              accept, emit, div_start, div_done;
    logic [RATE_W-1:0] div_q;
    logic [7:0]        b;
    logic [15:0]       coded, dec;
    logic [2:0]        need;
    logic [16:0]       sum16;
    logic [8:0]        sum8;

    voc_dfm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (9'd256 - {1'b0, fb0_reg}),
        .done     (div_done),
        .quotient (div_q)
    );

    assign s_tready = (st_reg != ST_DIV) && (!ov_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    always_comb
    begin
        st_next = st_reg; chk_next = chk_reg; fbi_next = fbi_reg; ofs_next = ofs_reg;
        pver_next = pver_reg; cver_next = cver_reg; idm_next = idm_reg; bk_next = bk_reg;
        bl_next = bl_reg; rate_next = rate_reg; bits_next = bits_reg; ch_next = ch_reg;
        fb0_next = fb0_reg; fb1_next = fb1_reg; fb2_next = fb2_reg; fi_next = fi_reg;
        ov_next = ov_reg && !m_tready;
        okind_next = okind_reg; osmp_next = osmp_reg;
        emit = 1'b0; div_start = 1'b0;
        coded = '0; dec = '0; need = 3'd1; sum16 = '0; sum8 = '0;
        if (cfg_wen)
            chk_next = cfg_wdata;
        if (st_reg == ST_DIV && div_done)
        begin
            rate_next = div_q;
            emit = 1'b1; okind_next = KIND_FORMAT; osmp_next = '0;
            fbi_next = '0; fi_next = '0;
            st_next = (bl_reg != '0) ? ST_DATA : ST_BLKHDR;
        end
        else if (accept)
        begin
            if (s_tuser)
            begin
                st_next = ST_HEADER; fbi_next = '0; ofs_next = '0; pver_next = '0;
                cver_next = '0; idm_next = 1'b1; bk_next = '0; bl_next = '0;
                rate_next = '0; bits_next = 8'd8; ch_next = 8'd1; fi_next = '0;
            end
            case (st_next)
                ST_HEADER:
                begin
                    if (fbi_next < IDENT_LEN && b != ident_char(fbi_next))
                        idm_next = 1'b0;
                    if (fbi_next == 5'd20) ofs_next[7:0]   = b;
                    if (fbi_next == 5'd21) ofs_next[15:8]  = b;
                    if (fbi_next == 5'd22) pver_next[7:0]  = b;
                    if (fbi_next == 5'd23) pver_next[15:8] = b;
                    if (fbi_next == 5'd24) cver_next       = b;
                    if (fbi_next == HDR_LAST)
                    begin
                        coded = {b, cver_next};
                        dec = (coded - VER_OFFSET) ^ VER_MASK;
                        if (chk_reg && (!idm_next || dec != pver_next))
                        begin
                            st_next = ST_DONE;
                            emit = 1'b1; okind_next = KIND_BAD; osmp_next = '0;
                        end
                        else
                        begin
                            bl_next = (ofs_next > HDR_LEN) ? 24'(ofs_next - HDR_LEN) : '0;
                            fbi_next = '0; fi_next = '0;
                            st_next = (bl_next != '0) ? ST_SKIP : ST_BLKHDR;
                        end
                    end
                    else
                    begin
                        fbi_next = fbi_next + 5'd1;
                    end
                end
                ST_SKIP:
                begin
                    if (bl_next != '0)
                        bl_next = bl_next - 24'd1;
                    if (bl_next == '0)
                    begin
                        fbi_next = '0; fi_next = '0; st_next = ST_BLKHDR;
                    end
                end
                ST_BLKHDR:
                begin
                    if (fbi_next == '0)
                    begin
                        bk_next = b;
                        if (b == BLK_END)
                        begin
                            st_next = ST_DONE;
                            emit = 1'b1; okind_next = KIND_END; osmp_next = '0;
                        end
                        else
                        begin
                            bl_next = '0; fbi_next = 5'd1;
                        end
                    end
                    else
                    begin
                        case (fbi_next[1:0])
                            2'd1:    bl_next[7:0]   = bl_next[7:0] | b;
                            2'd2:    bl_next[15:8]  = bl_next[15:8] | b;
                            default: bl_next[23:16] = bl_next[23:16] | b;
                        endcase
                        if (fbi_next >= 5'd3)
                        begin
                            if (bk_next == BLK_SND)
                            begin
                                bl_next = (bl_next > 24'd2) ? bl_next - 24'd2 : '0;
                                st_next = ST_SUB; fbi_next = '0;
                            end
                            else if (bk_next == BLK_SNDEX)
                            begin
                                bl_next = (bl_next > 24'd12) ? bl_next - 24'd12 : '0;
                                st_next = ST_SUB; fbi_next = '0;
                            end
                            else
                            begin
                                fbi_next = '0; fi_next = '0;
                                if (bl_next == '0)
                                    st_next = ST_BLKHDR;
                                else if (bk_next == BLK_CONT)
                                    st_next = ST_DATA;
                                else
                                    st_next = ST_SKIP;
                            end
                        end
                        else
                        begin
                            fbi_next = fbi_next + 5'd1;
                        end
                    end
                end
                ST_SUB:
                begin
                    if (bk_next == BLK_SND)
                    begin
                        if (fbi_next == '0)
                        begin
                            fb0_next = b; fbi_next = 5'd1;
                        end
                        else
                        begin
                            if (b == 8'd0)
                            begin
                                bits_next = 8'd8; ch_next = 8'd1;
                            end
                            div_start = 1'b1;
                            st_next = ST_DIV;
                        end
                    end
                    else
                    begin
                        if (fbi_next == 5'd0) rate_next = RATE_W'(b);
                        if (fbi_next == 5'd1) rate_next = RATE_W'({b, rate_next[7:0]});
                        if (fbi_next == 5'd4) bits_next = b;
                        if (fbi_next == 5'd5) ch_next = b;
                        if (fbi_next >= 5'd11)
                        begin
                            emit = 1'b1; okind_next = KIND_FORMAT; osmp_next = '0;
                            fbi_next = '0; fi_next = '0;
                            st_next = (bl_next != '0) ? ST_DATA : ST_BLKHDR;
                        end
                        else
                        begin
                            fbi_next = fbi_next + 5'd1;
                        end
                    end
                end
                ST_DATA:
                begin
                    need = (bits_next == 8'd8) ? 3'd1 : 3'd2;
                    if (ch_next != 8'd1)
                        need = {need[1:0], 1'b0};
                    if (bl_next != '0)
                        bl_next = bl_next - 24'd1;
                    sum8  = {1'b0, fb0_next} + {1'b0, b};
                    sum16 = {1'b0, fb1_next, fb0_next} + {1'b0, b, fb2_next};
                    if ({1'b0, fi_next} + 3'd1 >= need)
                    begin
                        emit = 1'b1; okind_next = KIND_SAMPLE;
                        if (need == 3'd1 || (need == 3'd2 && ch_next == 8'd1))
                            osmp_next = b;
                        else if (need == 3'd2)
                            osmp_next = sum8[8:1];
                        else
                            osmp_next = sum16[16:9];
                        fi_next = '0;
                    end
                    else if (fi_next < 2'd3)
                    begin
                        case (fi_next)
                            2'd0:    fb0_next = b;
                            2'd1:    fb1_next = b;
                            default: fb2_next = b;
                        endcase
                        fi_next = fi_next + 2'd1;
                    end
                    if (bl_next == '0)
                    begin
                        fbi_next = '0; fi_next = '0; st_next = ST_BLKHDR;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (emit)
            ov_next = 1'b1;
        orate_next = emit ? rate_next : orate_reg;
        obits_next = emit ? bits_next : obits_reg;
        och_next   = emit ? ch_next : och_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_HEADER; chk_reg <= 1'b1; fbi_reg <= '0; ofs_reg <= '0;
            pver_reg <= '0; cver_reg <= '0; idm_reg <= 1'b1; bk_reg <= '0;
            bl_reg <= '0; rate_reg <= '0; bits_reg <= 8'd8; ch_reg <= 8'd1;
            fi_reg <= '0; ov_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next; chk_reg <= chk_next; fbi_reg <= fbi_next; ofs_reg <= ofs_next;
            pver_reg <= pver_next; cver_reg <= cver_next; idm_reg <= idm_next;
            bk_reg <= bk_next; bl_reg <= bl_next; rate_reg <= rate_next;
            bits_reg <= bits_next; ch_reg <= ch_next; fi_reg <= fi_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fb0_reg <= fb0_next; fb1_reg <= fb1_next; fb2_reg <= fb2_next;
        okind_reg <= okind_next; osmp_reg <= osmp_next; orate_reg <= orate_next;
        obits_reg <= obits_next; och_reg <= och_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tuser  = okind_reg;
    assign m_tdata  = {4'd0, och_reg, obits_reg, orate_reg, osmp_reg};
endmodule
`default_nettype wire
